>>> rtl/fpti_pkg.sv
// Shared types, constants and helpers for the four-level page table insert block.
// No dependencies; all other files but fpti_checker refer to this package by scoped names.
package fpti_pkg;

   // Pool geometry
   localparam int POOL_NODES       = 16;
   localparam int ENTRIES_PER_NODE = 512;
   localparam int IDX_W            = $clog2(ENTRIES_PER_NODE);
   localparam int NODE_W           = $clog2(POOL_NODES);
   localparam int ADDR_W           = NODE_W + IDX_W;
   localparam int CNT_W            = $clog2(POOL_NODES + 1);
   localparam int CLEAR_LEN        = POOL_NODES * ENTRIES_PER_NODE;

   // Field widths
   localparam int VA_W       = 48;
   localparam int PA_W       = 52;
   localparam int FLAG_W     = 12;
   localparam int FRAME_W    = 40;
   localparam int PAGE_SHIFT = 12;
   localparam int VPN_W      = VA_W - PAGE_SHIFT;
   localparam int NODES_W    = 5;
   localparam int TAKEN_W    = 2;
   localparam int LVL_W      = 2;

   // Stored entry: frame number (bits 51..12) over the present bit
   localparam int ENTRY_W = FRAME_W + 1;

   // Index bit positions within the virtual address
   localparam int L0_SHIFT = 39;
   localparam int L1_SHIFT = 30;
   localparam int L2_SHIFT = 21;
   localparam int L3_SHIFT = 12;

   localparam logic [LVL_W-1:0] LVL_TOP  = 2'd0;
   localparam logic [LVL_W-1:0] LVL_LAST = 2'd2;
   localparam logic [LVL_W-1:0] LVL_LEAF = 2'd3;

   // Microprogram steps
   typedef enum logic [2:0] {
      STEP_CLEAR,
      STEP_IDLE,
      STEP_READ,
      STEP_EVAL,
      STEP_CHECK,
      STEP_LINK,
      STEP_LEAF,
      STEP_REPLY
   } fpti_step_type;

   // Jump conditions
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_REQ,
      COND_WALK_MORE,
      COND_FAIL,
      COND_LINKS_LEFT,
      COND_RSP_BUSY,
      COND_CLR_BUSY
   } fpti_cond_type;

   // One control word
   typedef struct packed {
      logic          clear;
      logic          accept;
      logic          read;
      logic          eval;
      logic          check;
      logic          link;
      logic          leaf;
      logic          emit;
      fpti_cond_type cond;
      fpti_step_type target;
      fpti_step_type next;
   } fpti_ctrl_type;

   // Datapath status seen by the sequencer
   typedef struct packed {
      logic req_valid;
      logic walk_more;
      logic fail;
      logic links_left;
      logic rsp_busy;
      logic clr_busy;
   } fpti_flags_type;

   // Control store
   function automatic fpti_ctrl_type fpti_rom(input fpti_step_type step);
      fpti_ctrl_type w;
      w = '{clear: 1'b0, accept: 1'b0, read: 1'b0, eval: 1'b0, check: 1'b0,
            link: 1'b0, leaf: 1'b0, emit: 1'b0, cond: COND_NEVER,
            target: STEP_IDLE, next: STEP_IDLE};
      case (step)
         STEP_CLEAR: begin
            w.clear = 1'b1; w.cond = COND_CLR_BUSY;
            w.target = STEP_CLEAR; w.next = STEP_IDLE;
         end
         STEP_IDLE: begin
            w.accept = 1'b1; w.cond = COND_REQ;
            w.target = STEP_READ; w.next = STEP_IDLE;
         end
         STEP_READ: begin
            w.read = 1'b1; w.next = STEP_EVAL;
         end
         STEP_EVAL: begin
            w.eval = 1'b1; w.cond = COND_WALK_MORE;
            w.target = STEP_READ; w.next = STEP_CHECK;
         end
         STEP_CHECK: begin
            w.check = 1'b1; w.cond = COND_FAIL;
            w.target = STEP_REPLY; w.next = STEP_LINK;
         end
         STEP_LINK: begin
            w.link = 1'b1; w.cond = COND_LINKS_LEFT;
            w.target = STEP_LINK; w.next = STEP_LEAF;
         end
         STEP_LEAF: begin
            w.leaf = 1'b1; w.next = STEP_REPLY;
         end
         STEP_REPLY: begin
            w.emit = 1'b1; w.cond = COND_RSP_BUSY;
            w.target = STEP_REPLY; w.next = STEP_IDLE;
         end
         default: begin
            w.next = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

   // Table index for one level, taken from the virtual page number
   function automatic logic [IDX_W-1:0] level_index(input logic [VPN_W-1:0] vpn,
                                                    input logic [LVL_W-1:0] lvl);
      logic [IDX_W-1:0] idx;
      case (lvl)
         2'd0:    idx = vpn[L0_SHIFT-PAGE_SHIFT +: IDX_W];
         2'd1:    idx = vpn[L1_SHIFT-PAGE_SHIFT +: IDX_W];
         2'd2:    idx = vpn[L2_SHIFT-PAGE_SHIFT +: IDX_W];
         default: idx = vpn[L3_SHIFT-PAGE_SHIFT +: IDX_W];
      endcase
      return idx;
   endfunction

endpackage

>>> rtl/fpti_req_if.sv
// Request channel: valid/ready handshake with the mapping request payload.
// Depends on fpti_pkg for field widths.
interface fpti_req_if;
   logic                         valid;
   logic                         ready;
   logic [fpti_pkg::VA_W-1:0]    vaddr;
   logic [fpti_pkg::PA_W-1:0]    paddr;
   logic [fpti_pkg::FLAG_W-1:0]  page_flags;

   modport source (output valid, vaddr, paddr, page_flags, input ready);
   modport sink   (input valid, vaddr, paddr, page_flags, output ready);
endinterface

>>> rtl/fpti_rsp_if.sv
// Response channel: valid/ready handshake with the insert result payload.
// Depends on fpti_pkg for field widths.
interface fpti_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          status;
   logic [fpti_pkg::TAKEN_W-1:0]  tables_taken;
   logic [fpti_pkg::NODES_W-1:0]  nodes_in_use;
   logic [fpti_pkg::PA_W-1:0]     leaf_value;

   modport source (output valid, status, tables_taken, nodes_in_use, leaf_value,
                   input ready);
   modport sink   (input valid, status, tables_taken, nodes_in_use, leaf_value,
                   output ready);
endinterface

>>> rtl/fpti_csr_if.sv
// Configuration write channel carrying the pool base frame register.
// Depends on fpti_pkg for the register width.
interface fpti_csr_if;
   logic                          valid;
   logic                          ready;
   logic [fpti_pkg::FRAME_W-1:0]  pool_base_frame;

   modport source (output valid, pool_base_frame, input ready);
   modport sink   (input valid, pool_base_frame, output ready);
endinterface

>>> rtl/four_level_page_table_insert.sv
// Four-level page table insert. Each request maps one 4 KiB virtual page: the
// block walks the three upper table levels from the root node, links fresh
// nodes from a fixed pool where an entry is not present, and writes the frame
// number of the physical address ORed with the page flags, with bit 0 of that
// value as the present bit, into the leaf entry. If a linked pointer lands
// outside the pool, or the pool has too few free nodes, nothing is written and
// the response reports status 1. All table entries sit in one single-port
// store, so the walk's dependent reads and the link writes run one after
// another. The reply step waits while the previous response has not been
// taken; the finished response waits in an output register, so a new request
// is taken while it is still pending. After reset all POOL_NODES * 512 store
// entries are cleared one entry per cycle, during which no request is accepted;
// configuration writes are taken at any time.
// Depends on fpti_pkg, the channel interfaces, fpti_sequencer and fpti_datapath.
module four_level_page_table_insert (
   input  logic        clock,
   input  logic        reset,
   fpti_req_if.sink    req_port,
   fpti_rsp_if.source  rsp_port,
   fpti_csr_if.sink    csr_port
);

   fpti_pkg::fpti_ctrl_type  ctrl;
   fpti_pkg::fpti_flags_type flags;

   fpti_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   fpti_datapath u_dp (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .flags (flags),
      .req   (req_port),
      .rsp   (rsp_port),
      .csr   (csr_port)
   );

endmodule

>>> rtl/fpti_sequencer.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on fpti_pkg for the step, condition and control word types.
module fpti_sequencer (
   input  logic                     clock,
   input  logic                     reset,
   input  fpti_pkg::fpti_flags_type flags,
   output fpti_pkg::fpti_ctrl_type  ctrl
);

   fpti_pkg::fpti_step_type step_ff;
   fpti_pkg::fpti_step_type step_in;
   logic                    jump;

   // Control word for the current step
   always_comb begin
      ctrl = fpti_pkg::fpti_rom(step_ff);
   end

   // Condition select and next step
   always_comb begin
      case (ctrl.cond)
         fpti_pkg::COND_REQ:        jump = flags.req_valid;
         fpti_pkg::COND_WALK_MORE:  jump = flags.walk_more;
         fpti_pkg::COND_FAIL:       jump = flags.fail;
         fpti_pkg::COND_LINKS_LEFT: jump = flags.links_left;
         fpti_pkg::COND_RSP_BUSY:   jump = flags.rsp_busy;
         fpti_pkg::COND_CLR_BUSY:   jump = flags.clr_busy;
         default:                   jump = 1'b0;
      endcase
      step_in = jump ? ctrl.target : ctrl.next;
   end

   // Step counter; reset starts the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= fpti_pkg::STEP_CLEAR;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

>>> rtl/fpti_datapath.sv
// Datapath: table store, walk registers, node allocator, config and result registers.
// Depends on fpti_pkg and the three channel interfaces; driven by fpti_sequencer.
module fpti_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  fpti_pkg::fpti_ctrl_type  ctrl,
   output fpti_pkg::fpti_flags_type flags,
   fpti_req_if.sink                 req,
   fpti_rsp_if.source               rsp,
   fpti_csr_if.sink                 csr
);

   // Table store and its registered read data
   logic [fpti_pkg::ENTRY_W-1:0] mem [fpti_pkg::CLEAR_LEN];
   logic [fpti_pkg::ENTRY_W-1:0] rd_data_ff;

   // Control registers
   logic [fpti_pkg::ADDR_W-1:0]  clr_cnt_ff,  clr_cnt_in;
   logic [fpti_pkg::LVL_W-1:0]   lvl_ff,      lvl_in;
   logic [fpti_pkg::NODE_W-1:0]  node_ff,     node_in;
   logic                         fail_ff,     fail_in;
   logic [fpti_pkg::TAKEN_W-1:0] taken_ff,    taken_in;
   logic [fpti_pkg::CNT_W-1:0]   free_ff,     free_in;
   logic [fpti_pkg::FRAME_W-1:0] base_ff,     base_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   // Request payload
   logic [fpti_pkg::VPN_W-1:0]   vpn_ff;
   logic [fpti_pkg::PA_W-1:0]    leaf_ff;

   // Result payload
   logic                           rsp_status_ff;
   logic [fpti_pkg::TAKEN_W-1:0]   rsp_taken_ff;
   logic [fpti_pkg::NODES_W-1:0]   rsp_nodes_ff;
   logic [fpti_pkg::PA_W-1:0]      rsp_leaf_ff;

   logic                           accept;
   logic                           rsp_load;
   logic                           present;
   logic [fpti_pkg::FRAME_W-1:0]   diff;
   logic                           stale;
   logic [fpti_pkg::LVL_W-1:0]     need;
   logic [fpti_pkg::CNT_W:0]       free_sum;
   logic                           short_pool;
   logic [fpti_pkg::IDX_W-1:0]     idx;
   logic [fpti_pkg::ADDR_W-1:0]    addr;
   logic                           wr_en;
   logic [fpti_pkg::ENTRY_W-1:0]   wr_data;
   logic [fpti_pkg::FRAME_W-1:0]   new_frame;
   logic                           do_link;
   logic [fpti_pkg::CNT_W+fpti_pkg::NODES_W-1:0] nodes_wide;

   // Handshakes
   assign req.ready = ctrl.accept;
   assign csr.ready = 1'b1;
   assign accept    = ctrl.accept && req.valid;
   assign rsp_load  = ctrl.emit && (!rsp_valid_ff || rsp.ready);

   // Walk evaluation on the entry read in the previous step
   assign present = rd_data_ff[0];
   assign diff    = rd_data_ff[fpti_pkg::ENTRY_W-1:1] - base_ff;
   assign stale   = diff >= fpti_pkg::FRAME_W'(fpti_pkg::POOL_NODES);

   // Free node check
   assign need       = fpti_pkg::LVL_LEAF - lvl_ff;
   assign free_sum   = {1'b0, free_ff} + (fpti_pkg::CNT_W + 1)'(need);
   assign short_pool = free_sum > (fpti_pkg::CNT_W + 1)'(fpti_pkg::POOL_NODES);

   // Store address and write data
   assign idx       = fpti_pkg::level_index(vpn_ff, lvl_ff);
   assign new_frame = base_ff + fpti_pkg::FRAME_W'(free_ff);
   assign do_link   = ctrl.link && (lvl_ff != fpti_pkg::LVL_LEAF);

   always_comb begin
      addr    = ctrl.clear ? clr_cnt_ff : {node_ff, idx};
      wr_en   = ctrl.clear || do_link || ctrl.leaf;
      wr_data = '0;
      if (do_link) begin
         wr_data = {new_frame, 1'b1};
      end else if (ctrl.leaf) begin
         wr_data = {leaf_ff[fpti_pkg::PA_W-1:fpti_pkg::PAGE_SHIFT], leaf_ff[0]};
      end
   end

   // Flags back to the sequencer
   always_comb begin
      flags.req_valid  = req.valid;
      flags.walk_more  = present && !stale && (lvl_ff != fpti_pkg::LVL_LAST);
      flags.fail       = fail_ff || short_pool;
      flags.links_left = lvl_ff < fpti_pkg::LVL_LAST;
      flags.rsp_busy   = rsp_valid_ff && !rsp.ready;
      flags.clr_busy   = clr_cnt_ff != fpti_pkg::ADDR_W'(fpti_pkg::CLEAR_LEN - 1);
   end

   // Next values of the control registers
   always_comb begin
      clr_cnt_in   = clr_cnt_ff;
      lvl_in       = lvl_ff;
      node_in      = node_ff;
      fail_in      = fail_ff;
      taken_in     = taken_ff;
      free_in      = free_ff;
      base_in      = csr.valid ? csr.pool_base_frame : base_ff;
      rsp_valid_in = rsp_load ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

      if (ctrl.clear && flags.clr_busy) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
      end
      if (accept) begin
         lvl_in   = fpti_pkg::LVL_TOP;
         node_in  = '0;
         fail_in  = 1'b0;
         taken_in = '0;
      end
      if (ctrl.eval && present) begin
         if (stale) begin
            fail_in = 1'b1;
         end else begin
            node_in = diff[fpti_pkg::NODE_W-1:0];
            lvl_in  = lvl_ff + 1'b1;
         end
      end
      if (ctrl.check && short_pool) begin
         fail_in = 1'b1;
      end
      if (do_link) begin
         node_in  = free_ff[fpti_pkg::NODE_W-1:0];
         free_in  = free_ff + 1'b1;
         lvl_in   = lvl_ff + 1'b1;
         taken_in = taken_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         lvl_ff       <= fpti_pkg::LVL_TOP;
         node_ff      <= '0;
         fail_ff      <= 1'b0;
         taken_ff     <= '0;
         free_ff      <= fpti_pkg::CNT_W'(1);
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_cnt_ff   <= clr_cnt_in;
         lvl_ff       <= lvl_in;
         node_ff      <= node_in;
         fail_ff      <= fail_in;
         taken_ff     <= taken_in;
         free_ff      <= free_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Table store: one write or one read per cycle, registered read data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (ctrl.read) begin
         rd_data_ff <= mem[addr];
      end
   end

   // Request payload capture
   always_ff @(posedge clock) begin
      if (accept) begin
         vpn_ff  <= req.vaddr[fpti_pkg::VA_W-1:fpti_pkg::PAGE_SHIFT];
         leaf_ff <= req.paddr | fpti_pkg::PA_W'(req.page_flags);
      end
   end

   // Result register; refused requests report zero tables taken and a zero leaf value
   assign nodes_wide = {{fpti_pkg::NODES_W{1'b0}}, free_ff};

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= fail_ff;
         rsp_taken_ff  <= fail_ff ? '0 : taken_ff;
         rsp_nodes_ff  <= nodes_wide[fpti_pkg::NODES_W-1:0];
         rsp_leaf_ff   <= fail_ff ? '0 : leaf_ff;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.tables_taken = rsp_taken_ff;
   assign rsp.nodes_in_use = rsp_nodes_ff;
   assign rsp.leaf_value   = rsp_leaf_ff;

endmodule

>>> rtl/fpti_checker.sv
// Port-level checks for the page table insert block, bound to the top level.
// Depends only on the top level's port signals.
module fpti_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_status,
   input logic [1:0]  rsp_tables_taken,
   input logic [4:0]  rsp_nodes_in_use,
   input logic [51:0] rsp_leaf_value
);

   // No request is taken in the cycle after reset: the clearing pass runs
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request accepted while the table store is being cleared");

   // A refused request allocates nothing and reports no leaf
   a_refused_is_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_tables_taken == 2'd0 && rsp_leaf_value == '0)
      else $error("refused response carries allocation or leaf data");

   // A stalled response stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_tables_taken)
         && $stable(rsp_nodes_in_use) && $stable(rsp_leaf_value))
      else $error("response payload changed while stalled");

endmodule

bind four_level_page_table_insert fpti_checker u_fpti_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_port.ready),
   .rsp_valid        (rsp_port.valid),
   .rsp_ready        (rsp_port.ready),
   .rsp_status       (rsp_port.status),
   .rsp_tables_taken (rsp_port.tables_taken),
   .rsp_nodes_in_use (rsp_port.nodes_in_use),
   .rsp_leaf_value   (rsp_port.leaf_value)
);
